@@ design/lbsw_pkg.sv @@
// shared types and constants for the loss budget stop-and-wait sender
`timescale 1ns / 1ps

package lbsw_pkg;

  localparam int WINDOW_SLOTS = 100;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int LOSS_W       = 7;
  localparam int ATT_W        = 4;
  localparam int SEQ_W        = 32;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 1;

  // event kinds
  localparam logic [1:0] FUNC_NEW     = 2'd0;
  localparam logic [1:0] FUNC_ACK     = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [2:0] ST_TRANSMIT   = 3'd0;
  localparam logic [2:0] ST_RETRANSMIT = 3'd1;
  localparam logic [2:0] ST_DELIVERED  = 3'd2;
  localparam logic [2:0] ST_LOSS_OK    = 3'd3;
  localparam logic [2:0] ST_GAVE_UP    = 3'd4;
  localparam logic [2:0] ST_IGNORED    = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_LOSSES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 1'd1;

  typedef struct packed {
    logic [1:0]       func;
    logic             ack_flag;
    logic [SEQ_W-1:0] ack_seq;
  } evt_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SEQ_W-1:0]  seq_number;
    logic [LOSS_W-1:0] window_losses;
  } res_t;

  // mark update from the controller to the window store
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic              mark;
    logic [SLOT_W-1:0] rd_addr;
  } mark_req_t;

endpackage

@@ design/loss_budget_stop_and_wait_sender.sv @@
// top level of the loss budget stop-and-wait sender
`timescale 1ns / 1ps

// Stop-and-wait sender with a loss budget. Each event (new packet, ack or timeout) gives
// exactly one result: transmit, retransmit, delivered, loss accepted, gave up or ignored.
// An event is decided in the decision stage between the event register and the result
// register, so one event per cycle is sustained while the result side does not stall; an
// accepted event is held in the event register and its result then in the result
// register. The delivered/lost window is a one-bit store with a valid flop per slot; the
// mark of the current slot is prefetched each cycle, so no clearing pass is needed after
// reset. Configuration writes take effect at once and belong in idle periods.

module loss_budget_stop_and_wait_sender (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            evt_valid,
  output logic                            evt_stall,
  input  lbsw_pkg::evt_t                  evt,
  output logic                            res_valid,
  input  logic                            res_stall,
  output lbsw_pkg::res_t                  res,
  input  logic                            cfg_we,
  input  logic [lbsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbsw_pkg::CFG_W-1:0]      cfg_data
);

  logic                          s1_valid;
  lbsw_pkg::evt_t                s1_evt;
  logic                          s1_fire;
  logic                          evt_take;
  logic [lbsw_pkg::LOSS_W-1:0]   allowed_losses;
  logic [lbsw_pkg::ATT_W-1:0]    max_attempts;
  logic                          cur_mark;
  lbsw_pkg::mark_req_t           mark_req;
  lbsw_pkg::res_t                result;

  assign s1_fire   = s1_valid && (!res_valid || !res_stall);
  assign evt_stall = s1_valid && !s1_fire;
  assign evt_take  = evt_valid && !evt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_losses <= '0;
      max_attempts   <= lbsw_pkg::ATT_W'(6);
    end else if (cfg_we) begin
      case (cfg_index)
        lbsw_pkg::CFG_ALLOWED_LOSSES: allowed_losses <= cfg_data;
        lbsw_pkg::CFG_MAX_ATTEMPTS:   max_attempts   <= cfg_data[lbsw_pkg::ATT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      s1_evt <= evt;
    end
  end

  lbsw_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .go             (s1_fire),
    .evt            (s1_evt),
    .allowed_losses (allowed_losses),
    .max_attempts   (max_attempts),
    .cur_mark       (cur_mark),
    .req            (mark_req),
    .result         (result)
  );

  lbsw_marks u_marks (
    .clk      (clk),
    .rst      (rst),
    .req      (mark_req),
    .cur_mark (cur_mark)
  );

  // result register, held while the far side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= result;
    end
  end

`ifndef SYNTHESIS
  a_losses_in_window: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.window_losses <= lbsw_pkg::LOSS_W'(lbsw_pkg::WINDOW_SLOTS))
    else $error("window loss count beyond window size");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> res_valid)
    else $error("decided event did not reach the result register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    evt_stall |-> s1_valid && res_valid && res_stall)
    else $error("event stall raised with room in the pipeline");

  a_status_code_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.status == lbsw_pkg::ST_TRANSMIT || res.status == lbsw_pkg::ST_RETRANSMIT
                   || res.status == lbsw_pkg::ST_DELIVERED || res.status == lbsw_pkg::ST_LOSS_OK
                   || res.status == lbsw_pkg::ST_GAVE_UP || res.status == lbsw_pkg::ST_IGNORED))
    else $error("result status outside the defined codes");
`endif

endmodule

@@ design/lbsw_marks.sv @@
// window of delivered/lost marks with the mark of the current slot held ready
`timescale 1ns / 1ps

module lbsw_marks (
  input  logic                  clk,
  input  logic                  rst,
  input  lbsw_pkg::mark_req_t   req,
  output logic                  cur_mark
);

  logic [lbsw_pkg::WINDOW_SLOTS-1:0] marks;
  logic [lbsw_pkg::WINDOW_SLOTS-1:0] written;
  logic                              mark_rd;
  logic                              written_rd;
  logic                              fwd;
  logic                              fwd_mark;

  always_ff @(posedge clk) begin
    if (req.we) begin
      marks[req.addr] <= req.mark;
    end
    mark_rd <= marks[req.rd_addr];
  end

  // entries never written read as delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      written_rd <= 1'b0;
      fwd        <= 1'b0;
      fwd_mark   <= 1'b1;
    end else begin
      if (req.we) begin
        written[req.addr] <= 1'b1;
      end
      written_rd <= written[req.rd_addr];
      fwd        <= req.we && (req.addr == req.rd_addr);
      fwd_mark   <= req.mark;
    end
  end

  assign cur_mark = fwd ? fwd_mark : (written_rd ? mark_rd : 1'b1);

endmodule

@@ design/lbsw_ctrl.sv @@
// sender state and the per-event decision
`timescale 1ns / 1ps

module lbsw_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  lbsw_pkg::evt_t                evt,
  input  logic [lbsw_pkg::LOSS_W-1:0]   allowed_losses,
  input  logic [lbsw_pkg::ATT_W-1:0]    max_attempts,
  input  logic                          cur_mark,
  output lbsw_pkg::mark_req_t           req,
  output lbsw_pkg::res_t                result
);

  logic                          busy, busy_next;
  logic [lbsw_pkg::ATT_W-1:0]    sends_done, sends_done_next;
  logic                          loss_checked, loss_checked_next;
  logic [lbsw_pkg::SLOT_W-1:0]   slot_pointer, slot_pointer_next;
  logic [lbsw_pkg::LOSS_W-1:0]   loss_count, loss_count_next;
  logic [lbsw_pkg::SEQ_W-1:0]    next_sequence, next_sequence_next;

  logic [lbsw_pkg::SLOT_W:0]     slot_inc;
  logic [lbsw_pkg::SLOT_W-1:0]   slot_adv;
  logic [lbsw_pkg::LOSS_W-1:0]   loss_if_lost;
  logic [lbsw_pkg::LOSS_W-1:0]   loss_if_deliv;
  logic                          ack_ok;
  logic [2:0]                    status;
  logic                          mark_we;
  logic                          mark_val;

  assign slot_inc = {1'b0, slot_pointer} + 1'b1;
  assign slot_adv = (slot_inc >= (lbsw_pkg::SLOT_W+1)'(lbsw_pkg::WINDOW_SLOTS))
                    ? '0 : slot_inc[lbsw_pkg::SLOT_W-1:0];

  // running count after marking the current slot lost or delivered
  assign loss_if_lost  = cur_mark ? loss_count + 1'b1 : loss_count;
  assign loss_if_deliv = cur_mark ? loss_count : loss_count - 1'b1;

  assign ack_ok = (evt.func == lbsw_pkg::FUNC_ACK) && evt.ack_flag
                  && (evt.ack_seq == next_sequence);

  always_comb begin
    busy_next          = busy;
    sends_done_next    = sends_done;
    loss_checked_next  = loss_checked;
    slot_pointer_next  = slot_pointer;
    loss_count_next    = loss_count;
    next_sequence_next = next_sequence;
    status             = lbsw_pkg::ST_IGNORED;
    mark_we            = 1'b0;
    mark_val           = 1'b1;
    case (evt.func)
      lbsw_pkg::FUNC_NEW: begin
        if (!busy) begin
          busy_next         = 1'b1;
          sends_done_next   = lbsw_pkg::ATT_W'(1);
          loss_checked_next = 1'b0;
          status            = lbsw_pkg::ST_TRANSMIT;
        end
      end
      lbsw_pkg::FUNC_ACK, lbsw_pkg::FUNC_TIMEOUT: begin
        if (busy) begin
          if (ack_ok) begin
            mark_we            = 1'b1;
            mark_val           = 1'b1;
            loss_count_next    = loss_if_deliv;
            slot_pointer_next  = slot_adv;
            next_sequence_next = next_sequence + 1'b1;
            busy_next          = 1'b0;
            status             = lbsw_pkg::ST_DELIVERED;
          end else if (sends_done < max_attempts) begin
            mark_we         = 1'b1;
            mark_val        = 1'b0;
            loss_count_next = loss_if_lost;
            if (!loss_checked && (loss_if_lost <= allowed_losses)) begin
              slot_pointer_next  = slot_adv;
              next_sequence_next = next_sequence + 1'b1;
              busy_next          = 1'b0;
              status             = lbsw_pkg::ST_LOSS_OK;
            end else begin
              loss_checked_next = 1'b1;
              sends_done_next   = sends_done + 1'b1;
              status            = lbsw_pkg::ST_RETRANSMIT;
            end
          end else begin
            busy_next = 1'b0;
            status    = lbsw_pkg::ST_GAVE_UP;
          end
        end
      end
      default: begin
        status = lbsw_pkg::ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      sends_done    <= '0;
      loss_checked  <= 1'b0;
      slot_pointer  <= '0;
      loss_count    <= '0;
      next_sequence <= '0;
    end else if (go) begin
      busy          <= busy_next;
      sends_done    <= sends_done_next;
      loss_checked  <= loss_checked_next;
      slot_pointer  <= slot_pointer_next;
      loss_count    <= loss_count_next;
      next_sequence <= next_sequence_next;
    end
  end

  // read address follows the slot the next event will see
  assign req.we      = go && mark_we;
  assign req.addr    = slot_pointer;
  assign req.mark    = mark_val;
  assign req.rd_addr = go ? slot_pointer_next : slot_pointer;

  assign result.status        = status;
  assign result.seq_number    = next_sequence;
  assign result.window_losses = loss_count_next;

endmodule
